// ===== src/fit_policy_block_allocator_macros.svh =====
// Assertion macros shared by the allocator RTL.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FPBA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FPBA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== src/fpba_pkg.sv =====
// Package: sizes, codes, scan state and types of the fit-policy block allocator.
package fpba_pkg;

    localparam int NUM_BLOCKS  = 16;
    localparam int SIZE_BITS   = 16;
    localparam int IDX_BITS    = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    localparam int OPCODE_BITS = 1;
    localparam int SLOT_BITS   = 4;
    localparam int VALUE_BITS  = 16;
    localparam int STATUS_BITS = 2;
    localparam int POLICY_BITS = 2;

    typedef logic [IDX_BITS-1:0]    t_idx;
    typedef logic [SIZE_BITS-1:0]   t_size;
    typedef logic [OPCODE_BITS-1:0] t_opcode;
    typedef logic [STATUS_BITS-1:0] t_status;
    typedef logic [POLICY_BITS-1:0] t_policy;

    localparam t_opcode OP_LOAD    = 1'b0;
    localparam t_opcode OP_REQUEST = 1'b1;

    localparam t_status ST_LOADED  = 2'd0;
    localparam t_status ST_ALLOC   = 2'd1;
    localparam t_status ST_NONE    = 2'd2;

    localparam t_policy POL_FIRST  = 2'd0;
    localparam t_policy POL_BEST   = 2'd1;
    localparam t_policy POL_WORST  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_DONE
    } t_state;

    // Current pick of a scan.
    typedef struct packed {
        logic  vld;
        t_idx  idx;
        t_size size;
    } t_best;

endpackage

// ===== src/fpba_ram.sv =====
// Generic simple dual-port RAM with registered read.
module fpba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/fpba_cmp.sv =====
// Shared fit compare unit: decide whether one slot replaces the current pick.
module fpba_cmp (
    input  fpba_pkg::t_policy i_policy,
    input  fpba_pkg::t_size   i_cand_size,
    input  logic              i_cand_used,
    input  fpba_pkg::t_size   i_want,
    input  fpba_pkg::t_best   i_best,
    output logic              o_take
);
    import fpba_pkg::*;

    logic adequate;
    logic smaller;
    logic larger;

    assign adequate = !i_cand_used && (i_cand_size >= i_want);
    assign smaller  = i_cand_size < i_best.size;
    assign larger   = i_cand_size > i_best.size;

    // Strict compares keep ties on the lower index.
    always_comb begin
        o_take = 1'b0;
        if (adequate) begin
            if (!i_best.vld) begin
                o_take = 1'b1;
            end else if (i_policy == POL_BEST) begin
                o_take = smaller;
            end else if (i_policy == POL_WORST) begin
                o_take = larger;
            end
        end
    end

endmodule

// ===== src/fit_policy_block_allocator.sv =====
// Top level: fixed-partition block allocator with first, best or worst fit.
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+---------------------------------
//  in      | to block  | i_in_valid / o_in_stall    | opcode, slot_index, size_value
//  out     | from block| o_out_valid / i_out_stall  | status, chosen_slot, chosen_size
//  cfg     | to block  | i_cfg_valid / o_cfg_ready  | fit policy (2 bits)
//
// A load word goes from S_IDLE to S_DONE; a request runs S_SCAN and S_LAST
// first; no new word is taken until S_DONE returns to S_IDLE. The request time
// is set by the scan: one read of the slot size RAM and one pass through the
// shared compare unit per slot. A result waits in S_DONE while the output
// register is full and stalled. Synchronous active-low reset marks every slot
// used, sets first fit; the size RAM needs no clearing: used slots never win.
module fit_policy_block_allocator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  fpba_pkg::t_opcode                   i_opcode,
    input  logic [fpba_pkg::SLOT_BITS-1:0]      i_slot_index,
    input  logic [fpba_pkg::VALUE_BITS-1:0]     i_size_value,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output fpba_pkg::t_status                   o_status,
    output logic [fpba_pkg::SLOT_BITS-1:0]      o_chosen_slot,
    output logic [fpba_pkg::VALUE_BITS-1:0]     o_chosen_size,
    // configuration channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  fpba_pkg::t_policy                   i_cfg_data
);
    import fpba_pkg::*;

    `include "fit_policy_block_allocator_macros.svh"

    t_state  r_state, n_state;
    t_policy r_fit_policy;

    // Captured request word.
    t_opcode               r_op;
    logic [SLOT_BITS-1:0]  r_load_slot;
    t_size                 r_want;

    // Scan pipeline: address stage, then compare stage in the next cycle.
    t_idx  r_rd_idx;
    logic  r_cand_vld;
    t_idx  r_cand_idx;
    t_best r_best;

    logic [NUM_BLOCKS-1:0] r_used;

    logic                  r_out_valid;
    t_status               r_out_status;
    logic [SLOT_BITS-1:0]  r_out_slot;
    logic [VALUE_BITS-1:0] r_out_size;

    logic  in_acc;
    logic  in_range;
    logic  scan_en;
    logic  last_addr;
    logic  out_free;
    logic  out_load;
    logic  ram_we;
    t_size ram_rdata;
    logic  take;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign in_range  = 32'(i_slot_index) < NUM_BLOCKS;
    assign last_addr = r_rd_idx == IDX_BITS'(NUM_BLOCKS - 1);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign ram_we    = in_acc && (i_opcode == OP_LOAD) && in_range;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_opcode == OP_REQUEST) ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (last_addr) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        o_in_stall = 1'b1;
        scan_en    = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
            end
            S_SCAN: begin
                scan_en = 1'b1;
            end
            S_LAST: begin
                scan_en = 1'b0;
            end
            S_DONE: begin
                out_load = out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    assign o_cfg_ready = 1'b1;

    fpba_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (NUM_BLOCKS)
    ) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (IDX_BITS'(i_slot_index)),
        .i_wdata (SIZE_BITS'(i_size_value)),
        .i_re    (scan_en),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    fpba_cmp u_cmp (
        .i_policy    (r_fit_policy),
        .i_cand_size (ram_rdata),
        .i_cand_used (r_used[r_cand_idx]),
        .i_want      (r_want),
        .i_best      (r_best),
        .o_take      (take)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fit_policy <= POL_FIRST;
            r_used       <= '1;
            r_cand_vld   <= 1'b0;
            r_best.vld   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cand_vld <= scan_en;
            if (i_cfg_valid && o_cfg_ready) begin
                r_fit_policy <= i_cfg_data;
            end
            // Free the slot on load; claim the pick when its result goes out.
            if (ram_we) begin
                r_used[IDX_BITS'(i_slot_index)] <= 1'b0;
            end
            if (out_load && (r_op == OP_REQUEST) && r_best.vld) begin
                r_used[r_best.idx] <= 1'b1;
            end
            // Drop the pick on a new word; advance it when the compare unit says take.
            if (in_acc) begin
                r_best.vld <= 1'b0;
            end else if (r_cand_vld && take) begin
                r_best.vld  <= 1'b1;
                r_best.idx  <= r_cand_idx;
                r_best.size <= ram_rdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload and scan datapath.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op        <= i_opcode;
            r_load_slot <= i_slot_index;
            r_want      <= SIZE_BITS'(i_size_value);
            r_rd_idx    <= '0;
        end else if (scan_en && !last_addr) begin
            r_rd_idx <= r_rd_idx + 1'b1;
        end
        r_cand_idx <= r_rd_idx;
        if (out_load) begin
            if (r_op == OP_LOAD) begin
                r_out_status <= ST_LOADED;
                r_out_slot   <= r_load_slot;
                r_out_size   <= '0;
            end else if (r_best.vld) begin
                r_out_status <= ST_ALLOC;
                r_out_slot   <= SLOT_BITS'(r_best.idx);
                r_out_size   <= VALUE_BITS'(r_best.size);
            end else begin
                r_out_status <= ST_NONE;
                r_out_slot   <= '0;
                r_out_size   <= '0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_chosen_slot = r_out_slot;
    assign o_chosen_size = r_out_size;

    `FPBA_ASSERT_IMP(a_cand_in_scan, i_clk, i_rst_n, r_cand_vld,
        (r_state == S_SCAN) || (r_state == S_LAST))
    `FPBA_ASSERT_IMP(a_last_after_scan, i_clk, i_rst_n, r_state == S_LAST,
        $past(r_state) == S_SCAN)
    `FPBA_ASSERT_IMP(a_pick_fits, i_clk, i_rst_n,
        (r_state == S_DONE) && (r_op == OP_REQUEST) && r_best.vld,
        r_best.size >= r_want)
    `FPBA_ASSERT_NXT(a_pick_claimed, i_clk, i_rst_n,
        out_load && (r_op == OP_REQUEST) && r_best.vld,
        r_used[$past(r_best.idx)])

endmodule

// ===== bench/fit_policy_block_allocator_test.sv =====
// Testbench for the fit-policy block allocator: predicted grants under random flow control.
`timescale 1ns / 100ps

// One result word as the block reports it.
typedef struct {
    fpba_pkg::t_status               status;
    logic [fpba_pkg::SLOT_BITS-1:0]  slot;
    logic [fpba_pkg::VALUE_BITS-1:0] size;
} t_alloc_word;

// Tracks the slot table and policy, predicts each word's result, checks results in order.
class alloc_tracker;
    fpba_pkg::t_policy policy;
    fpba_pkg::t_size   slot_size [fpba_pkg::NUM_BLOCKS];
    bit                slot_taken[fpba_pkg::NUM_BLOCKS];
    t_alloc_word       due_words[$];
    int                errors;

    function new();
        policy   = fpba_pkg::POL_FIRST;
        errors   = 0;
        // Unloaded slots count as taken, so nothing is granted before a load.
        foreach (slot_size[i]) begin
            slot_size[i]  = '0;
            slot_taken[i] = 1'b1;
        end
    endfunction

    // Apply one accepted input word to the table and queue the result it must produce.
    function void note_word(fpba_pkg::t_opcode op, logic [fpba_pkg::SLOT_BITS-1:0] idx,
                            logic [fpba_pkg::VALUE_BITS-1:0] value);
        t_alloc_word     w;
        int              pick;
        fpba_pkg::t_size want;
        want = fpba_pkg::t_size'(value);
        if (op == fpba_pkg::OP_LOAD) begin
            // A reload frees the slot whether or not it was granted.
            if (idx < fpba_pkg::NUM_BLOCKS) begin
                slot_size[idx]  = want;
                slot_taken[idx] = 1'b0;
            end
            w.status = fpba_pkg::ST_LOADED;
            w.slot   = idx;
            w.size   = '0;
        end else begin
            // Scan in index order; a strict compare keeps ties on the lowest index.
            pick = -1;
            for (int i = 0; i < fpba_pkg::NUM_BLOCKS; i++) begin
                if (!slot_taken[i] && slot_size[i] >= want) begin
                    if (pick < 0) begin
                        pick = i;
                        // First fit, and the spare policy code, stop at the first candidate.
                        if (policy != fpba_pkg::POL_BEST && policy != fpba_pkg::POL_WORST)
                            break;
                    end else if (policy == fpba_pkg::POL_BEST
                                 && slot_size[i] < slot_size[pick]) begin
                        pick = i;
                    end else if (policy == fpba_pkg::POL_WORST
                                 && slot_size[i] > slot_size[pick]) begin
                        pick = i;
                    end
                end
            end
            if (pick >= 0) begin
                slot_taken[pick] = 1'b1;
                w.status = fpba_pkg::ST_ALLOC;
                w.slot   = pick[fpba_pkg::SLOT_BITS-1:0];
                w.size   = fpba_pkg::VALUE_BITS'(slot_size[pick]);
            end else begin
                w.status = fpba_pkg::ST_NONE;
                w.slot   = '0;
                w.size   = '0;
            end
        end
        due_words.push_back(w);
    endfunction

    function void flag_field(string field, int unsigned want, int unsigned got);
        errors++;
        $error("%s: expected %0d, got %0d", field, want, got);
    endfunction

    // Compare one accepted result word with the oldest prediction.
    function void check_word(fpba_pkg::t_status status, logic [fpba_pkg::SLOT_BITS-1:0] slot,
                             logic [fpba_pkg::VALUE_BITS-1:0] size);
        t_alloc_word want;
        if (due_words.size() == 0) begin
            errors++;
            $error("result word with nothing expected: status %0d slot %0d size %0d",
                   status, slot, size);
            return;
        end
        want = due_words.pop_front();
        if (status !== want.status)
            flag_field("status", want.status, status);
        if (slot !== want.slot)
            flag_field("chosen_slot", want.slot, slot);
        if (size !== want.size)
            flag_field("chosen_size", want.size, size);
    endfunction
endclass

module fit_policy_block_allocator_test;
    import fpba_pkg::*;

    // Spare policy code: must behave as first fit.
    localparam t_policy POL_SPARE     = 2'd3;
    localparam int      PHASE_WORDS   = 256;
    localparam int      LONG_HOLD     = 400;
    localparam int      SETTLE_CYCLES = 2 * (NUM_BLOCKS + 3) + 8;
    localparam int      DRAIN_LIMIT   = 50000;

    typedef enum int {
        PACE_FREE,
        PACE_COIN,
        PACE_CHOKE
    } t_pace;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_in_valid   = 1'b0;
    logic                  o_in_stall;
    t_opcode               i_opcode     = OP_LOAD;
    logic [SLOT_BITS-1:0]  i_slot_index = '0;
    logic [VALUE_BITS-1:0] i_size_value = '0;
    logic                  o_out_valid;
    logic                  i_out_stall  = 1'b0;
    t_status               o_status;
    logic [SLOT_BITS-1:0]  o_chosen_slot;
    logic [VALUE_BITS-1:0] o_chosen_size;
    logic                  i_cfg_valid  = 1'b0;
    logic                  o_cfg_ready;
    t_policy               i_cfg_data   = POL_FIRST;

    // Handshake between stimulus and the output pacer for the one long hold-off.
    bit hold_armed = 1'b0;
    bit hold_done  = 1'b0;

    alloc_tracker sb = new();
    t_policy      policy_plan[6];

    fit_policy_block_allocator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_slot_index  (i_slot_index),
        .i_size_value  (i_size_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_chosen_slot (o_chosen_slot),
        .o_chosen_size (o_chosen_size),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Check every result word taken at a rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_word(o_status, o_chosen_slot, o_chosen_size);
    end

    // Offer one word at the falling edge and hold it until a rising edge takes it.
    task automatic send_word(input t_opcode op, input logic [SLOT_BITS-1:0] idx,
                             input logic [VALUE_BITS-1:0] value);
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_slot_index <= idx;
        i_size_value <= value;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall)
                break;
        end
        sb.note_word(op, idx, value);
    endtask

    // Drop valid for a number of cycles.
    task automatic pause_input(input int cycles);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Stop offering, wait for every predicted word, then wait for the block to settle.
    task automatic wait_idle();
        int guard;
        pause_input(1);
        guard = 0;
        while (sb.due_words.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_policy(input t_policy pol);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= pol;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready)
                break;
        end
        sb.policy = pol;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Bursts of load/request words; request sizes lean on sizes already in the table so
    // grants happen often and ties appear.
    task automatic random_phase(input int count);
        int                    left, burst, gap, roll, trim;
        t_opcode               op;
        logic [SLOT_BITS-1:0]  idx;
        logic [VALUE_BITS-1:0] value, base;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 12);
            if (burst > left)
                burst = left;
            repeat (burst) begin
                op   = ($urandom_range(0, 99) < 55) ? OP_REQUEST : OP_LOAD;
                idx  = SLOT_BITS'($urandom_range(0, NUM_BLOCKS - 1));
                roll = $urandom_range(0, 99);
                if (op == OP_LOAD) begin
                    if (roll < 45)
                        value = VALUE_BITS'($urandom_range(0, 31));
                    else if (roll < 80)
                        value = VALUE_BITS'($urandom_range(0, 65535));
                    else
                        value = VALUE_BITS'(($urandom_range(0, 1) == 0)
                                            ? $urandom_range(0, 1)
                                            : $urandom_range(65534, 65535));
                end else begin
                    if (roll < 50) begin
                        base  = sb.slot_size[SLOT_BITS'($urandom_range(0, NUM_BLOCKS - 1))];
                        trim  = $urandom_range(0, 3);
                        value = (base >= trim) ? VALUE_BITS'(base - trim) : '0;
                    end else if (roll < 75) begin
                        value = VALUE_BITS'($urandom_range(0, 31));
                    end else if (roll < 90) begin
                        value = VALUE_BITS'($urandom_range(0, 65535));
                    end else begin
                        value = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF;
                    end
                end
                send_word(op, idx, value);
            end
            left -= burst;
            // Roughly a third of the bursts run straight into the next one.
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 15);
            if (gap > 0)
                pause_input(gap);
        end
    endtask

    // Output pacing: stretches of no stall, coin-flip stall and heavy stall, plus one
    // long hold-off that backs the block up into its input.
    initial begin : out_pacing
        int    stretch;
        t_pace mode;
        @(posedge i_rst_n);
        forever begin
            if (hold_armed && !hold_done) begin
                for (int n = 0; n < LONG_HOLD; n++) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b1;
                end
                hold_done = 1'b1;
            end
            mode    = t_pace'($urandom_range(0, 2));
            stretch = $urandom_range(8, 64);
            repeat (stretch) begin
                @(negedge i_clk);
                case (mode)
                    PACE_FREE: i_out_stall <= 1'b0;
                    PACE_COIN: i_out_stall <= ($urandom_range(0, 1) == 0);
                    default:   i_out_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        policy_plan[0] = POL_BEST;
        policy_plan[1] = POL_WORST;
        policy_plan[2] = POL_SPARE;
        policy_plan[3] = POL_FIRST;
        policy_plan[4] = POL_WORST;
        policy_plan[5] = POL_BEST;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, first fit from reset. Slot index on requests is junk and must be ignored.
        send_word(OP_REQUEST, 4'hA, 16'd0);      // nothing loaded: zero size finds no slot
        send_word(OP_LOAD,    4'd0, 16'd0);
        send_word(OP_LOAD,    4'hF, 16'hFFFF);
        send_word(OP_LOAD,    4'd5, 16'd100);
        send_word(OP_REQUEST, 4'h5, 16'd0);      // slot 0, zero size
        send_word(OP_REQUEST, 4'h0, 16'd0);      // slot 0 taken: slot 5
        send_word(OP_REQUEST, 4'hF, 16'd0);      // slot 15
        send_word(OP_REQUEST, 4'h3, 16'd0);      // all taken: a zero size must not reuse one
        send_word(OP_LOAD,    4'hF, 16'hFFFF);   // reload a taken slot frees it
        send_word(OP_REQUEST, 4'h0, 16'hFFFF);   // largest size fits exactly
        send_word(OP_LOAD,    4'd3, 16'd7);
        send_word(OP_LOAD,    4'd9, 16'd7);
        send_word(OP_LOAD,    4'hC, 16'hFFFE);
        send_word(OP_REQUEST, 4'h1, 16'hFFFF);   // one short of the request: no grant
        send_word(OP_REQUEST, 4'h6, 16'd7);      // tie on size: lowest index
        send_word(OP_LOAD,    4'd3, 16'd1);
        send_word(OP_REQUEST, 4'h9, 16'd2);      // slot 3 too small now
        send_word(OP_REQUEST, 4'hE, 16'd1);
        send_word(OP_REQUEST, 4'h2, 16'hFFFE);
        wait_idle();

        foreach (policy_plan[p]) begin
            write_policy(policy_plan[p]);
            if (p == 1)
                hold_armed = 1'b1;
            random_phase(PHASE_WORDS);
            wait_idle();
        end

        if (sb.errors == 0 && sb.due_words.size() == 0) begin
            $display("SUCCESS");
        end else begin
            if (sb.due_words.size() != 0)
                $error("%0d expected result words never arrived", sb.due_words.size());
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
